/* rtl/core/tlb_lru_lookup_fill_defines.svh */
// Assertion macros for the TLB with LRU replacement.
// Included by the top level, which checks its own control logic; no other dependencies.
`ifndef TLB_LRU_LOOKUP_FILL_DEFINES_SVH
`define TLB_LRU_LOOKUP_FILL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLBLRU_ASSERT_IMP(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLBLRU_ASSERT_NXT(label, clk_i, rst_ni, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tlblru_pkg.sv */
// Shared types and constants for the TLB with LRU replacement.
// Used by the entry cell, the hit reduction and the top level; no dependencies.
`timescale 1ns / 1ps

package tlblru_pkg;

  localparam int TLB_ENTRIES_DEF = 64;
  localparam int PAGE_W          = 36;
  localparam int FRAME_W         = 40;
  localparam int COST_W          = 4;
  localparam int CAP_W           = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                operation;
    logic [PAGE_W-1:0]  page_number;
    logic               walk_ok;
    logic [FRAME_W-1:0] walk_frame;
    logic [COST_W-1:0]  walk_accesses;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic [COST_W-1:0]  cost;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY
  } state_t;

  // Commands broadcast from the controller to every entry cell.
  typedef struct packed {
    logic look;
    logic flush;
    logic promote;
    logic fill;
    logic evict;
  } cell_ctl_t;

endpackage

/* rtl/core/tlblru_cell.sv */
// One TLB entry: valid bit, page tag, frame, age rank and a registered tag match.
// Depends on tlblru_pkg; the free-slot search runs through the valid bit of the left neighbour.
`timescale 1ns / 1ps

module tlblru_cell #(
  parameter int AGE_W = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlblru_pkg::cell_ctl_t        ctl,
  input  logic [tlblru_pkg::PAGE_W-1:0]  key_page,
  input  logic [tlblru_pkg::FRAME_W-1:0] wr_frame,
  input  logic [AGE_W-1:0]             hit_age,
  input  logic [AGE_W-1:0]             victim_age,
  input  logic                         prev_valid,
  output logic                         valid,
  output logic                         match,
  output logic [AGE_W-1:0]             age,
  output logic [tlblru_pkg::FRAME_W-1:0] frame
);
  import tlblru_pkg::*;

  logic               valid_r, valid_nxt;
  logic               match_r, match_nxt;
  logic [AGE_W-1:0]   age_r, age_nxt;
  logic [PAGE_W-1:0]  page_r;
  logic [FRAME_W-1:0] frame_r;
  logic               take;
  logic               wr_en;

  // Valid entries always form a prefix of the row, so the first free slot is
  // the empty cell whose left neighbour is occupied.
  assign take  = ctl.evict ? (valid_r && (age_r == victim_age)) : (!valid_r && prev_valid);
  assign wr_en = ctl.fill && take;

  always_comb begin
    valid_nxt = valid_r;
    match_nxt = match_r;
    age_nxt   = age_r;
    if (ctl.look) begin
      match_nxt = valid_r && (page_r == key_page);
    end
    if (ctl.flush) begin
      valid_nxt = 1'b0;
      age_nxt   = '0;
    end else if (ctl.promote) begin
      if (match_r) begin
        age_nxt = '0;
      end else if (valid_r && (age_r < hit_age)) begin
        age_nxt = age_r + 1'b1;
      end
    end else if (ctl.fill) begin
      if (take) begin
        valid_nxt = 1'b1;
        age_nxt   = '0;
      end else if (valid_r) begin
        age_nxt = age_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
      age_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
      age_r   <= age_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      page_r  <= key_page;
      frame_r <= wr_frame;
    end
  end

  assign valid = valid_r;
  assign match = match_r;
  assign age   = age_r;
  assign frame = frame_r;

endmodule

/* rtl/core/tlblru_reduce.sv */
// Collects the frame and age rank of the single matching entry from the cell row.
// Depends on tlblru_pkg for the frame width.
`timescale 1ns / 1ps

module tlblru_reduce #(
  parameter int TLB_ENTRIES = 64,
  parameter int AGE_W       = 6
) (
  input  logic [TLB_ENTRIES-1:0]         match_vec,
  input  logic [tlblru_pkg::FRAME_W-1:0] cell_frame [TLB_ENTRIES],
  input  logic [AGE_W-1:0]               cell_age   [TLB_ENTRIES],
  output logic                           hit,
  output logic [tlblru_pkg::FRAME_W-1:0] hit_frame,
  output logic [AGE_W-1:0]               hit_age
);
  import tlblru_pkg::*;

  // Tags are unique among valid entries, so at most one match bit is set and
  // an OR over the masked fields selects that entry.
  always_comb begin
    hit_frame = '0;
    hit_age   = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      hit_frame = hit_frame | (cell_frame[i] & {FRAME_W{match_vec[i]}});
      hit_age   = hit_age   | (cell_age[i]   & {AGE_W{match_vec[i]}});
    end
  end

  assign hit = |match_vec;

endmodule

/* rtl/core/tlb_lru_lookup_fill.sv */
// Fully associative TLB with true LRU replacement.
// Input channel (in_valid/in_ready/in_data) takes lookup or flush items; each item
// gives exactly one result on the output channel (out_valid/out_ready/out_data).
// A lookup that hits returns the stored frame with cost 1 and makes the entry the
// most recent. A miss returns the walk cost; a successful walk also returns and
// installs the walk frame, evicting the least recent entry once occupancy reaches
// the capacity. A flush empties the table and returns all zeros.
// The capacity register is written through cfg_valid/cfg_ready/cfg_data, always ready.
// After an item is accepted, ST_LOOK compares the page against every entry cell
// and registers the match; ST_APPLY then resolves the hit, updates tags and age ranks
// in all cells at once and registers the result. A new item is taken in ST_APPLY,
// while the last one resolves, unless the output stall below holds it.
// If the result register is still full and out_ready is low, the update cycle
// holds and in_ready stays low until the result is taken.
// Synchronous reset empties the table, sets capacity to 64 and leaves no result pending.
// Depends on tlblru_pkg, tlblru_cell, tlblru_reduce and the assertion macro header.
`timescale 1ns / 1ps
`include "tlb_lru_lookup_fill_defines.svh"

module tlb_lru_lookup_fill #(
  parameter int TLB_ENTRIES = tlblru_pkg::TLB_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tlblru_pkg::in_item_t         in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tlblru_pkg::out_item_t        out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tlblru_pkg::CAP_W-1:0] cfg_data
);
  import tlblru_pkg::*;

  localparam int AGE_W = $clog2(TLB_ENTRIES);
  localparam int OCC_W = $clog2(TLB_ENTRIES + 1);
  localparam int EXT_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  state_t             state_r, state_nxt;
  in_item_t           req_r;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  cell_ctl_t          ctl;
  logic               apply_go;
  logic               is_flush;
  logic               do_fill;
  logic               evict;
  logic [EXT_W-1:0]   cap_ext;
  logic [EXT_W-1:0]   eff_cap;
  logic [AGE_W-1:0]   victim_age;

  logic [TLB_ENTRIES-1:0] valid_vec;
  logic [TLB_ENTRIES-1:0] match_vec;
  logic [AGE_W-1:0]       cell_age   [TLB_ENTRIES];
  logic [FRAME_W-1:0]     cell_frame [TLB_ENTRIES];
  logic                   hit;
  logic [FRAME_W-1:0]     hit_frame;
  logic [AGE_W-1:0]       hit_age;

  // Capacity zero behaves as one; values above the table size saturate.
  assign cap_ext = EXT_W'(cap_r);
  assign eff_cap = (cap_r == '0) ? EXT_W'(1) :
                   ((cap_ext > EXT_W'(TLB_ENTRIES)) ? EXT_W'(TLB_ENTRIES) : cap_ext);
  assign evict      = (occ_r != '0) && (EXT_W'(occ_r) >= eff_cap);
  // Ranks of the valid entries are exactly 0 to occupancy-1, so the oldest is known.
  assign victim_age = AGE_W'(occ_r - 1'b1);

  assign is_flush = (req_r.operation == OP_FLUSH);
  assign do_fill  = !is_flush && !hit && req_r.walk_ok;
  assign apply_go = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ctl.look  = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (apply_go) begin
          in_ready    = 1'b1;
          ctl.flush   = is_flush;
          ctl.promote = !is_flush && hit;
          ctl.fill    = do_fill;
          ctl.evict   = do_fill && evict;
          state_nxt   = in_valid ? ST_LOOK : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    occ_nxt = occ_r;
    if (ctl.flush) begin
      occ_nxt = '0;
    end else if (ctl.fill && !ctl.evict) begin
      occ_nxt = occ_r + 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_APPLY && apply_go) begin
      out_valid_nxt = 1'b1;
      if (is_flush) begin
        out_nxt = '0;
      end else if (hit) begin
        out_nxt.hit   = 1'b1;
        out_nxt.frame = hit_frame;
        out_nxt.cost  = COST_W'(1);
      end else begin
        out_nxt.hit   = 1'b0;
        out_nxt.frame = req_r.walk_ok ? req_r.walk_frame : '0;
        out_nxt.cost  = req_r.walk_accesses;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
      cap_r       <= CAP_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      occ_r       <= occ_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
  end

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    logic left_valid;
    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
    end else begin : g_rest
      assign left_valid = valid_vec[i-1];
    end

    tlblru_cell #(
      .AGE_W(AGE_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .key_page   (req_r.page_number),
      .wr_frame   (req_r.walk_frame),
      .hit_age    (hit_age),
      .victim_age (victim_age),
      .prev_valid (left_valid),
      .valid      (valid_vec[i]),
      .match      (match_vec[i]),
      .age        (cell_age[i]),
      .frame      (cell_frame[i])
    );
  end

  tlblru_reduce #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .AGE_W      (AGE_W)
  ) u_reduce (
    .match_vec  (match_vec),
    .cell_frame (cell_frame),
    .cell_age   (cell_age),
    .hit        (hit),
    .hit_frame  (hit_frame),
    .hit_age    (hit_age)
  );

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `TLBLRU_ASSERT_IMP(a_single_match, clk, rst_n, state_r == ST_APPLY, $onehot0(match_vec), "more than one entry matched the page")
  `TLBLRU_ASSERT_IMP(a_occ_matches_valid, clk, rst_n, 1'b1, $countones(valid_vec) == occ_r, "occupancy disagrees with the valid entries")
  `TLBLRU_ASSERT_NXT(a_fill_grows, clk, rst_n, ctl.fill && !ctl.evict, occ_r == $past(occ_r) + 1'b1, "fill into a free slot did not raise occupancy")
  `TLBLRU_ASSERT_NXT(a_result_loaded, clk, rst_n, state_r == ST_APPLY && apply_go, out_valid_r, "resolved item left no result")

endmodule
